// ===== sv/azw_pkg.sv =====
// Shared constants, codes and types of the angle zero, wrap and moving average block.
package azw_pkg;

  // Field widths of the item and result transactions.
  localparam int unsigned SampleW = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned AngleW  = 17;
  localparam int unsigned TenthsW = 12;

  // Default number of angles that the moving average spans.
  localparam int unsigned DefFilterDepth = 16;

  // Button event codes. The remaining codes act as no event.
  localparam logic [KindW-1:0] KindClick  = 2'd1;
  localparam logic [KindW-1:0] KindDclick = 2'd2;

  // Divider of the average: 34-bit dividend, 18-bit divisor, 17-bit quotient.
  localparam int unsigned DivNumW = 34;
  localparam int unsigned DivDenW = 18;
  localparam int unsigned DivQuoW = 17;

  // A full turn is 360 degrees in Q8, spread over a raw span of 65535. The span is one
  // less than a power of two, so the scaled value is divided by folding its high half
  // onto its low half. Adding half the span first rounds half away from zero.
  localparam logic [AngleW-1:0]         AngleScale  = 17'd92160;
  localparam logic [SampleW+AngleW-1:0] AngleRound  = 33'd32767;
  localparam logic [AngleW:0]           AngleSpan   = 18'd65535;
  localparam logic [AngleW:0]           AngleSpanX2 = 18'd131070;

  // Wrap limits in Q8 degrees, one bit wider than an angle.
  localparam logic signed [AngleW:0] HalfTurn = 18'sd46080;
  localparam logic signed [AngleW:0] FullTurn = 18'sd92160;

  // Largest magnitude of the filtered output in tenths of a degree.
  localparam logic signed [TenthsW-1:0] TenthsMax = 12'sd1800;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivQuoW-1:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/azw_if.sv =====
// Valid/ready channel interfaces for the sample items and the angle results.
interface azw_in_if;
  import azw_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] raw_sample;
  logic [KindW-1:0]   kind;

  modport source (output valid, output raw_sample, output kind, input ready);
  modport sink (input valid, input raw_sample, input kind, output ready);
endinterface

interface azw_out_if;
  import azw_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [AngleW-1:0]  angle_q8;
  logic signed [TenthsW-1:0] filtered_tenths;
  logic                      calibrated;

  modport source (output valid, output angle_q8, output filtered_tenths, output calibrated,
                  input ready);
  modport sink (input valid, input angle_q8, input filtered_tenths, input calibrated,
                output ready);
endinterface

// ===== sv/azw_div.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
module azw_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  azw_pkg::div_req_t  req_i,
  output azw_pkg::div_rsp_t  rsp_o
);
  import azw_pkg::*;

  localparam int unsigned CntW = $clog2(DivQuoW);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivQuoW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;

  // The quotient register also holds the dividend bits not yet shifted in.
  assign trial = {rem_q, quo_q[DivQuoW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start && !busy_q) begin
      rem_d  = DivDenW'(req_i.num[DivNumW-1:DivQuoW]);
      quo_d  = req_i.num[DivQuoW-1:0];
      den_d  = req_i.den;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DivDenW]) begin
        rem_d = diff[DivDenW-1:0];
        quo_d = {quo_q[DivQuoW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivDenW-1:0];
        quo_d = {quo_q[DivQuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivQuoW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quo: quo_q};

endmodule

// ===== sv/angle_zero_wrap_moving_average.sv =====
// Top level of the angle zero, wrap and moving average block.
//
// Each input transaction carries one raw 16-bit angle sensor sample and a button
// event. A click stores the sample as the zero point and raises calibrated; a
// double click clears the zero point and calibrated; the event takes effect before
// the angle of that same sample is formed. The angle is (sample - zero) scaled to
// Q8 degrees with 360 degrees per 65535 counts, rounded half away from zero and
// wrapped once into (-180, 180]. It enters a ring of the last FILTER_DEPTH angles
// held in a synchronous memory, and a running sum of the ring is divided by the
// number of angles seen so far (up to FILTER_DEPTH) and rounded half away from zero
// to tenths of a degree. Every input transaction yields exactly one output
// transaction. One item is processed at a time, and most of its processing is
// spent in the 17-step pass of the bit-serial divider that forms the average. The
// angle scaling is a multiply, a fold that divides by 65535 with adds and compares,
// and the wrap, each a registered step of its own. A finished result sits in an
// output register, so the next item is accepted while the previous result still
// waits to be taken; a result that is still waiting when the next one is done
// holds the block until the sink takes it. The ring entries need no reset: an
// entry is read back only once the ring is full.
module angle_zero_wrap_moving_average #(
  parameter int unsigned FILTER_DEPTH = azw_pkg::DefFilterDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  azw_in_if.sink    in_i,
  azw_out_if.source out_o
);
  import azw_pkg::*;

  localparam int unsigned PosW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FILTER_DEPTH + 1);
  localparam int unsigned SumW = AngleW + $clog2(FILTER_DEPTH);

  // One-hot sequencer: scale, fold, wrap, ring update, average divide, hand-off.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_FOLD  = 8'b0000_0100,
    S_WRAP  = 8'b0000_1000,
    S_UPD   = 8'b0001_0000,
    S_TGO   = 8'b0010_0000,
    S_TWAIT = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Calibration state.
  logic [SampleW-1:0] zero_q, zero_d;
  logic               cal_q, cal_d;

  // Per-item working registers.
  logic                      sign_q, sign_d;
  logic [SampleW-1:0]        mag_q, mag_d;
  logic [SampleW+AngleW-1:0] prod_q, prod_d;
  logic [AngleW-1:0]         fold_hi_q, fold_hi_d;
  logic [AngleW:0]           fold_sum_q, fold_sum_d;
  logic signed [AngleW-1:0]  angle_q, angle_d;
  logic signed [TenthsW-1:0] tenths_q, tenths_d;

  // Filter state.
  logic [PosW-1:0]        pos_q, pos_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [SumW-1:0] sum_q, sum_d;

  // Ring memory with a registered read port.
  logic signed [AngleW-1:0] ring_q [FILTER_DEPTH];
  logic signed [AngleW-1:0] ring_rd_q;
  logic                     ring_we;

  // Output register.
  logic                      out_valid_q, out_valid_d;
  logic signed [AngleW-1:0]  out_angle_q, out_angle_d;
  logic signed [TenthsW-1:0] out_tenths_q, out_tenths_d;
  logic                      out_cal_q, out_cal_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                      accept;
  logic                      load;
  logic                      full;
  logic signed [SampleW:0]   diff_s;
  logic signed [SampleW:0]   diff_neg;
  logic [SampleW+AngleW-1:0] prod_rnd;
  logic [AngleW-1:0]         quo_mag;
  logic signed [AngleW:0]    quo_s;
  logic signed [AngleW:0]    wrap_s;
  logic signed [SumW-1:0]    sum_neg;
  logic [SumW-1:0]           sum_mag;
  logic signed [SumW-1:0]    leaving;
  logic [DivQuoW-1:0]        quo_neg;

  azw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (cnt_q == CntW'(FILTER_DEPTH));
  assign load       = (state_q == S_FIN) && (!out_valid_q || out_o.ready);
  assign ring_we    = (state_q == S_UPD);

  // The event is applied first; the difference uses the updated zero point.
  assign diff_s   = $signed({1'b0, in_i.raw_sample}) - $signed({1'b0, zero_d});
  assign diff_neg = -diff_s;

  // Rounded magnitude: (|diff| * scale + span / 2) / span. With hi and lo the halves
  // of the dividend, dividend = hi * 65535 + (hi + lo), and hi + lo is below three
  // spans, so the quotient is hi plus the number of whole spans in hi + lo.
  assign prod_rnd = prod_q + AngleRound;

  always_comb begin
    quo_mag = fold_hi_q;
    if (fold_sum_q >= AngleSpanX2) begin
      quo_mag = fold_hi_q + AngleW'(2);
    end else if (fold_sum_q >= AngleSpan) begin
      quo_mag = fold_hi_q + AngleW'(1);
    end
  end

  // Signed quotient of the angle scaling, then one wrap into (-180, 180].
  assign quo_s = sign_q ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
  always_comb begin
    wrap_s = quo_s;
    if (quo_s > HalfTurn) begin
      wrap_s = quo_s - FullTurn;
    end else if (quo_s <= -HalfTurn) begin
      wrap_s = quo_s + FullTurn;
    end
  end

  // The sum magnitude always fits, since the sum stays well inside its range.
  assign sum_neg = -sum_q;
  assign sum_mag = sum_q[SumW-1] ? sum_neg : sum_q;
  assign leaving = full ? SumW'(ring_rd_q) : '0;
  assign quo_neg = -div_rsp.quo;

  always_comb begin
    state_d    = state_q;
    zero_d     = zero_q;
    cal_d      = cal_q;
    sign_d     = sign_q;
    mag_d      = mag_q;
    prod_d     = prod_q;
    fold_hi_d  = fold_hi_q;
    fold_sum_d = fold_sum_q;
    angle_d    = angle_q;
    tenths_d   = tenths_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    div_req    = '{start: 1'b0, num: '0, den: '0};

    // The spare event code falls through both tests and acts as no event.
    if (accept) begin
      if (in_i.kind == KindClick) begin
        zero_d = in_i.raw_sample;
        cal_d  = 1'b1;
      end else if (in_i.kind == KindDclick) begin
        zero_d = '0;
        cal_d  = 1'b0;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          sign_d  = diff_s[SampleW];
          mag_d   = diff_s[SampleW] ? diff_neg[SampleW-1:0] : diff_s[SampleW-1:0];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = {{AngleW{1'b0}}, mag_q} * {{SampleW{1'b0}}, AngleScale};
        state_d = S_FOLD;
      end
      S_FOLD: begin
        fold_hi_d  = prod_rnd[SampleW+AngleW-1:SampleW];
        fold_sum_d = {1'b0, prod_rnd[SampleW+AngleW-1:SampleW]}
                   + (AngleW+1)'(prod_rnd[SampleW-1:0]);
        state_d    = S_WRAP;
      end
      S_WRAP: begin
        angle_d = wrap_s[AngleW-1:0];
        state_d = S_UPD;
      end
      S_UPD: begin
        // The overwritten entry leaves the sum only once the ring is full.
        sum_d = sum_q - leaving + SumW'(angle_q);
        cnt_d = full ? cnt_q : cnt_q + 1'b1;
        pos_d = (pos_q == PosW'(FILTER_DEPTH - 1)) ? '0 : pos_q + 1'b1;
        state_d = S_UPD == state_q ? S_TGO : state_q;
      end
      S_TGO: begin
        // Rounded magnitude: (20 * |sum| + 256 * count) / (512 * count).
        div_req.start = 1'b1;
        div_req.num   = (DivNumW'(sum_mag) << 4) + (DivNumW'(sum_mag) << 2)
                      + (DivNumW'(cnt_q) << 8);
        div_req.den   = DivDenW'(cnt_q) << 9;
        state_d       = S_TWAIT;
      end
      S_TWAIT: begin
        if (div_rsp.done) begin
          tenths_d = sum_q[SumW-1] ? quo_neg[TenthsW-1:0] : div_rsp.quo[TenthsW-1:0];
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: filled when the result is done, emptied by the sink.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_angle_d  = out_angle_q;
    out_tenths_d = out_tenths_q;
    out_cal_d    = out_cal_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d  = 1'b1;
      out_angle_d  = angle_q;
      out_tenths_d = tenths_q;
      out_cal_d    = cal_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      zero_q      <= '0;
      cal_q       <= 1'b0;
      pos_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      zero_q      <= zero_d;
      cal_q       <= cal_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q       <= sign_d;
    mag_q        <= mag_d;
    prod_q       <= prod_d;
    fold_hi_q    <= fold_hi_d;
    fold_sum_q   <= fold_sum_d;
    angle_q      <= angle_d;
    tenths_q     <= tenths_d;
    out_angle_q  <= out_angle_d;
    out_tenths_q <= out_tenths_d;
    out_cal_q    <= out_cal_d;
  end

  // The write position only moves in the update step, so the read port has
  // long settled on the entry that is about to be overwritten.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[pos_q] <= angle_q;
    end
    ring_rd_q <= ring_q[pos_q];
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.angle_q8        = out_angle_q;
  assign out_o.filtered_tenths = out_tenths_q;
  assign out_o.calibrated      = out_cal_q;

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input accepted while an item is in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FILTER_DEPTH))
    else $error("valid count exceeds the filter depth");

  a_angle_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (angle_q > -HalfTurn && angle_q <= HalfTurn))
    else $error("angle outside the wrapped range");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_tenths_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (tenths_q >= -TenthsMax && tenths_q <= TenthsMax))
    else $error("filtered output out of range");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the angle zero, wrap and moving average block.
import azw_pkg::*;

// Result of one sample as the block should report it.
typedef struct {
  logic signed [AngleW-1:0]  angle_q8;
  logic signed [TenthsW-1:0] tenths;
  logic                      calibrated;
} angle_result_t;

// Division rounded half away from zero; den is always positive here.
function automatic longint round_half_away(longint num, longint den);
  longint mag;
  longint quo;
  mag = (num < 0) ? -num : num;
  quo = (2 * mag + den) / (2 * den);
  return (num < 0) ? -quo : quo;
endfunction

// Q8 angle of a raw difference, wrapped once into (-180, 180] degrees.
function automatic longint q8_angle(longint diff);
  longint angle;
  angle = round_half_away(diff * longint'(AngleScale), longint'((1 << SampleW) - 1));
  if (angle > HalfTurn) angle -= FullTurn;
  if (angle <= -HalfTurn) angle += FullTurn;
  return angle;
endfunction

// Tracks the zero point and the window of angles, and holds the results still owed.
class angle_average_tracker #(int unsigned Depth = DefFilterDepth);
  logic [SampleW-1:0] zero_pt;
  logic               cal_flag;
  longint             window[Depth];
  int unsigned        wr_pos;
  int unsigned        fill;
  longint             angle_sum;
  angle_result_t      pending_angles[$];
  int unsigned        mismatch_count;

  function new();
    zero_pt        = '0;
    cal_flag       = 1'b0;
    wr_pos         = 0;
    fill           = 0;
    angle_sum      = 0;
    mismatch_count = 0;
  endfunction

  function void note_sample(logic [SampleW-1:0] raw, logic [KindW-1:0] kind);
    longint        angle;
    longint        tenths;
    angle_result_t res;
    if (kind == KindClick) begin
      zero_pt  = raw;
      cal_flag = 1'b1;
    end else if (kind == KindDclick) begin
      zero_pt  = '0;
      cal_flag = 1'b0;
    end
    angle = q8_angle(longint'(raw) - longint'(zero_pt));
    if (fill >= Depth) begin
      angle_sum -= window[wr_pos];
    end else begin
      fill++;
    end
    window[wr_pos] = angle;
    angle_sum += angle;
    wr_pos = (wr_pos + 1) % Depth;
    tenths = round_half_away(angle_sum * 10, longint'(fill) * 256);
    res.angle_q8   = angle[AngleW-1:0];
    res.tenths     = tenths[TenthsW-1:0];
    res.calibrated = cal_flag;
    pending_angles.push_back(res);
  endfunction

  function void check_result(logic signed [AngleW-1:0] angle_q8,
                             logic signed [TenthsW-1:0] tenths, logic calibrated);
    angle_result_t want;
    if (pending_angles.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result angle_q8 %0d filtered_tenths %0d calibrated %0b",
               $time, angle_q8, tenths, calibrated);
      return;
    end
    want = pending_angles.pop_front();
    if (want.angle_q8 !== angle_q8 || want.tenths !== tenths
        || want.calibrated !== calibrated) begin
      mismatch_count++;
      $display("%0t: angle_q8, filtered_tenths, calibrated: expected %0d %0d %0b, %s",
               $time, want.angle_q8, want.tenths, want.calibrated,
               $sformatf("actual %0d %0d %0b", angle_q8, tenths, calibrated));
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import azw_pkg::*;

  // Event codes the package leaves unnamed: no event, and the spare code that acts as none.
  localparam logic [KindW-1:0] KindNone  = 2'd0;
  localparam logic [KindW-1:0] KindSpare = 2'd3;

  localparam int unsigned FilterDepth = DefFilterDepth;
  localparam int unsigned RandItems   = 1030;

  // Ways in which the result side holds off ready.
  typedef enum int unsigned {
    SinkAlways,
    SinkCoin,
    SinkLongStall,
    SinkPattern
  } sink_mode_e;

  logic clk_i;
  logic rst_ni;

  azw_in_if  in_if ();
  azw_out_if out_if ();

  angle_average_tracker #(FilterDepth) sb;

  angle_zero_wrap_moving_average #(
    .FILTER_DEPTH(FilterDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // 8 ns clock period.
  always #4 clk_i = ~clk_i;

  // Offers one sample at a falling edge and holds it until a rising edge sees ready.
  // The expectation is logged at that same edge, so the tracker sees samples in
  // exactly the order in which the block accepted them.
  task automatic send_sample(input logic [SampleW-1:0] raw, input logic [KindW-1:0] kind);
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.raw_sample <= raw;
    in_if.kind       <= kind;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_sample(raw, kind);
  endtask

  // Drops valid for a number of cycles. The payload is scrambled meanwhile, so a block
  // that takes data without valid shows up as a mismatch.
  task automatic idle_input(input int unsigned cycles);
    @(negedge clk_i);
    in_if.valid      <= 1'b0;
    in_if.raw_sample <= SampleW'($urandom);
    in_if.kind       <= KindW'($urandom);
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Every accepted result transaction is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.angle_q8, out_if.filtered_tenths, out_if.calibrated);
  end

  // Result side: ready follows a stall pattern that changes after a random span.
  // Some stretches never stall, some toss a coin each cycle, some hold off for long
  // runs and some repeat a short rotating bit pattern.
  initial begin : result_sink
    sink_mode_e      mode;
    int unsigned     span;
    int unsigned     stall;
    logic [7:0]      pattern;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode    = sink_mode_e'($urandom_range(0, 3));
      span    = $urandom_range(20, 400);
      pattern = 8'($urandom) | 8'h01;
      stall   = 0;
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          SinkAlways: begin
            out_if.ready <= 1'b1;
          end
          SinkCoin: begin
            out_if.ready <= 1'($urandom_range(0, 1));
          end
          SinkLongStall: begin
            if (stall == 0 && $urandom_range(0, 49) == 0) stall = $urandom_range(10, 60);
            if (stall > 0) begin
              stall--;
              out_if.ready <= 1'b0;
            end else begin
              out_if.ready <= 1'b1;
            end
          end
          default: begin
            out_if.ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  // Main stimulus: reset, a directed opening, then random bursts of samples.
  initial begin : sample_source
    int unsigned        tie_raw;
    int unsigned        d;
    int unsigned        burst_left;
    int unsigned        gap;
    int unsigned        pick;
    logic [SampleW-1:0] raw;
    logic [KindW-1:0]   kind;

    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.raw_sample = '0;
    in_if.kind       = KindNone;
    sb               = new();

    // Reset is held from time zero and released at a falling edge, away from the rising edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Find a sample whose angle makes the very first average land exactly halfway
    // between two tenths, so the tie rounding of the average is exercised at once.
    tie_raw = 0;
    for (d = 1; d < 65536; d++) begin
      if (((q8_angle(longint'(d)) * 10) % 256) == 128) begin
        tie_raw = d;
        break;
      end
    end

    // Directed opening, back to back. With no zero set the difference is the raw sample itself.
    send_sample(16'(tie_raw), KindNone);
    send_sample(16'd0, KindNone);
    // A difference of a full turn maps to 360 degrees and wraps to zero.
    send_sample(16'hFFFF, KindNone);
    // Just below and just above the half turn: the second one wraps negative.
    send_sample(16'd32767, KindNone);
    send_sample(16'd32768, KindNone);
    // The spare event code must behave like no event.
    send_sample(16'd16384, KindSpare);
    // Click at the top of the range, then look a full turn and half turns below it.
    send_sample(16'hFFFF, KindClick);
    send_sample(16'd0, KindNone);
    send_sample(16'd32767, KindNone);
    send_sample(16'd32768, KindNone);
    // Click at the bottom of the range, then the opposite full turn.
    send_sample(16'd0, KindClick);
    send_sample(16'hFFFF, KindNone);
    // Double click drops calibration; the spare code must not bring it back.
    send_sample(16'd12345, KindDclick);
    send_sample(16'hFFFF, KindSpare);
    // Alternating bit patterns carry the window past full so old angles leave the sum.
    repeat (5) begin
      send_sample(16'hAAAA, KindNone);
      send_sample(16'h5555, KindNone);
    end

    // Random part. Samples come in bursts with gaps between them; about one burst
    // in four follows the previous one with no gap at all. A share of the samples is
    // aimed at the wrap point half a turn from the current zero and at the range ends.
    burst_left = 0;
    repeat (RandItems) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        if (gap > 0) idle_input(gap);
      end
      burst_left--;

      pick = $urandom_range(0, 99);
      if (pick < 80)      kind = KindNone;
      else if (pick < 88) kind = KindClick;
      else if (pick < 95) kind = KindDclick;
      else                kind = KindSpare;

      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        raw = sb.zero_pt + 16'd32766 + 16'($urandom_range(0, 3));
      end else if (pick < 18) begin
        case ($urandom_range(0, 3))
          0:       raw = '0;
          1:       raw = '1;
          2:       raw = sb.zero_pt;
          default: raw = sb.zero_pt - 16'd1;
        endcase
      end else begin
        raw = 16'($urandom);
      end
      send_sample(raw, kind);
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;

    // Drain: wait for every owed result, then watch a while longer than one item's
    // processing time so that a stray extra result is still caught.
    while (sb.pending_angles.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin : watchdog
    #6_000_000;
    $display("%0t: run timed out", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/azw_pkg.sv
sv/azw_if.sv
sv/azw_div.sv
sv/angle_zero_wrap_moving_average.sv
tb/sv/tb.sv
